// ===== hdl/utld_pkg.sv =====
package utld_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_BLOCK_LEN_DEF = 16;
    localparam int INDEX_WIDTH_DEF   = 27;
    localparam int FRAC_BITS_DEF     = 16;

    // Shortest block length; shorter settings act as this one.
    localparam int MIN_BLOCK_LEN = 6;

    // Field and register widths.
    localparam int BLOCK_VALUE_W = 16;
    localparam int BLOCK_LEN_W   = 5;
    localparam int INIT_BLOCKS_W = 20;
    localparam int TEST_BLOCKS_W = 27;
    localparam int END_SUM_W     = TEST_BLOCKS_W + 1;
    localparam int TERM_W        = 21;
    localparam int SUM_W         = 48;

    // Result transfer layout on m_tdata.
    localparam int TERM_LSB    = 0;
    localparam int SUM_LSB     = TERM_LSB + TERM_W;
    localparam int SAT_BIT     = SUM_LSB + SUM_W;
    localparam int TDATA_OUT_W = ((SAT_BIT + 1 + 7) / 8) * 8;

    // Width of the normalized mantissa in the log2 unit.
    localparam int NORM_W = 31;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [BLOCK_LEN_W-1:0]   BLOCK_LEN_RST   = 5'd6;
    localparam logic [INIT_BLOCKS_W-1:0] INIT_BLOCKS_RST = 20'd640;
    localparam logic [TEST_BLOCKS_W-1:0] TEST_BLOCKS_RST = 27'd1000;

    // Register numbers; byte address is four times the number.
    typedef enum logic [1:0] {
        REG_BLOCK_LEN   = 2'd0,
        REG_INIT_BLOCKS = 2'd1,
        REG_TEST_BLOCKS = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [BLOCK_LEN_W-1:0]   block_len;
        logic [INIT_BLOCKS_W-1:0] init_blocks;
        logic [TEST_BLOCKS_W-1:0] test_blocks;
    } cfg_t;

    // Classification of one item, handed from the front to the back.
    typedef struct packed {
        logic test;
        logic done;
    } item_flags_t;

    localparam int FLAGS_W = $bits(item_flags_t);

endpackage

// ===== hdl/utld_ram.sv =====
module utld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle; a read of the address
    // being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/utld_fifo.sv =====
module utld_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_pop;

    assign do_pop = pop && (level_reg != '0);

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (!push && do_pop) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = slot_reg[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

endmodule

// ===== hdl/utld_front.sv =====
module utld_front #(
    parameter int MAX_BLOCK_LEN = utld_pkg::MAX_BLOCK_LEN_DEF,
    parameter int INDEX_WIDTH   = utld_pkg::INDEX_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  utld_pkg::cfg_t                     cfg,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [utld_pkg::BLOCK_VALUE_W-1:0] s_tdata,
    input  logic [utld_pkg::QUEUE_LVL_W-1:0]   q_level,
    output logic                               q_push,
    output logic [INDEX_WIDTH-1:0]             q_dist,
    output utld_pkg::item_flags_t              q_flags
);

    import utld_pkg::*;

    localparam int ADDR_W = MAX_BLOCK_LEN;
    localparam int EW     = ((INDEX_WIDTH > END_SUM_W) ? INDEX_WIDTH : END_SUM_W) + 1;

    // Clearing pass over the table after reset.
    logic [ADDR_W:0]          clr_cnt_reg;
    logic                     clearing;

    logic [INDEX_WIDTH-1:0]   counter_reg, counter_next;

    // Item waiting for its table read.
    logic                     f1_valid_reg;
    logic [ADDR_W-1:0]        f1_addr_reg;
    logic [INDEX_WIDTH-1:0]   f1_index_reg;
    item_flags_t              f1_flags_reg;
    logic                     f1_ign_reg;
    logic                     f1_fwd_reg;
    logic [INDEX_WIDTH-1:0]   f1_fwd_val_reg;

    logic [BLOCK_LEN_W-1:0]   len;
    logic [ADDR_W-1:0]        mask;
    logic [ADDR_W-1:0]        addr_in;
    logic [EW-1:0]            qk_sum;
    logic [EW-1:0]            idx_max;
    logic [EW-1:0]            end_pt;
    logic [EW-1:0]            idx_ext;
    logic [INDEX_WIDTH-1:0]   idx_new;
    logic                     ignored;
    item_flags_t              flags_new;
    logic                     accept;
    logic [QUEUE_LVL_W:0]     occupancy;
    logic                     f1_write;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [INDEX_WIDTH-1:0]   ram_wdata;
    logic [INDEX_WIDTH-1:0]   ram_rdata;
    logic [INDEX_WIDTH-1:0]   last_seen;

    assign clearing = !clr_cnt_reg[ADDR_W];

    // Take an item only when the queue will have room for it and for the
    // item now waiting on the table read.
    assign occupancy = (QUEUE_LVL_W + 1)'(q_level) + (QUEUE_LVL_W + 1)'(f1_valid_reg);
    assign s_tready  = !clearing && (occupancy < (QUEUE_LVL_W + 1)'(QUEUE_DEPTH));
    assign accept    = s_tvalid && s_tready;

    // Effective block length and the table address it selects.
    always_comb begin
        if (cfg.block_len < BLOCK_LEN_W'(MIN_BLOCK_LEN)) begin
            len = BLOCK_LEN_W'(MIN_BLOCK_LEN);
        end else if (cfg.block_len > BLOCK_LEN_W'(MAX_BLOCK_LEN)) begin
            len = BLOCK_LEN_W'(MAX_BLOCK_LEN);
        end else begin
            len = cfg.block_len;
        end
        for (int j = 0; j < ADDR_W; j++) begin
            mask[j] = (BLOCK_LEN_W'(j) < len);
        end
        addr_in = s_tdata[ADDR_W-1:0] & mask;
    end

    // Phase of the item: initialization, test, or past the end.
    always_comb begin
        idx_max   = EW'({INDEX_WIDTH{1'b1}});
        qk_sum    = EW'(cfg.init_blocks) + EW'(cfg.test_blocks);
        end_pt    = (qk_sum > idx_max) ? idx_max : qk_sum;
        ignored   = (EW'(counter_reg) >= end_pt);
        idx_new   = counter_reg + 1'b1;
        idx_ext   = EW'(idx_new);
        flags_new.test = !ignored && (idx_ext > EW'(cfg.init_blocks));
        flags_new.done = ignored || (flags_new.test && (idx_ext == end_pt));
        counter_next   = counter_reg;
        if (accept && !ignored) begin
            counter_next = idx_new;
        end
    end

    // Table write: zeros during the clearing pass, else the item number.
    assign f1_write  = f1_valid_reg && !f1_ign_reg;
    assign ram_we    = clearing || f1_write;
    assign ram_waddr = clearing ? clr_cnt_reg[ADDR_W-1:0] : f1_addr_reg;
    assign ram_wdata = clearing ? '0 : f1_index_reg;

    utld_ram #(
        .WIDTH (INDEX_WIDTH),
        .DEPTH (2 ** MAX_BLOCK_LEN)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (addr_in),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            counter_reg  <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            counter_reg  <= counter_next;
            f1_valid_reg <= accept;
        end
    end

    // Item details and the forwarded write that the table read misses.
    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_addr_reg    <= addr_in;
            f1_index_reg   <= idx_new;
            f1_flags_reg   <= flags_new;
            f1_ign_reg     <= ignored;
            f1_fwd_reg     <= f1_write && (f1_addr_reg == addr_in);
            f1_fwd_val_reg <= f1_index_reg;
        end
    end

    // Distance to the last sighting goes to the queue.
    assign last_seen = f1_fwd_reg ? f1_fwd_val_reg : ram_rdata;
    assign q_push    = f1_valid_reg;
    assign q_dist    = f1_index_reg - last_seen;
    assign q_flags   = f1_flags_reg;

endmodule

// ===== hdl/utld_back.sv =====
module utld_back #(
    parameter int INDEX_WIDTH = utld_pkg::INDEX_WIDTH_DEF,
    parameter int FRAC_BITS   = utld_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_empty,
    input  logic [INDEX_WIDTH+utld_pkg::FLAGS_W-1:0] q_rdata,
    output logic                                   q_pop,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [utld_pkg::TDATA_OUT_W-1:0]       m_tdata,
    output logic                                   m_tuser,
    output logic                                   m_tlast
);

    import utld_pkg::*;

    localparam int E_W   = $clog2(INDEX_WIDTH);
    localparam int WIDE  = INDEX_WIDTH + NORM_W;
    localparam int EXT_W = TERM_W + E_W + FRAC_BITS;
    localparam int PAD_W = TDATA_OUT_W - SAT_BIT - 1;

    logic                   adv;

    // Leading-one stage.
    logic                   a_valid_reg;
    logic [INDEX_WIDTH-1:0] a_dist_reg;
    logic [E_W-1:0]         a_e_reg;
    item_flags_t            a_flags_reg;

    logic [INDEX_WIDTH-1:0] q_dist;
    item_flags_t            q_flags;
    logic [E_W-1:0]         e_new;

    // Normalize and squaring stages; index 0 holds the normalized mantissa.
    logic [FRAC_BITS:0]     v_reg;
    logic [NORM_W-1:0]      x_reg     [FRAC_BITS+1];
    logic [FRAC_BITS-1:0]   bits_reg  [FRAC_BITS+1];
    logic [E_W-1:0]         e_reg     [FRAC_BITS+1];
    item_flags_t            fl_reg    [FRAC_BITS+1];
    logic [NORM_W:0]        y_stage   [FRAC_BITS];

    logic [WIDE-1:0]        wide_dist;
    logic [WIDE-1:0]        wide_shift;

    logic [EXT_W-1:0]       term_ext;
    logic [TERM_W-1:0]      term_fin;
    logic [SUM_W:0]         sum_add;
    logic                   load;

    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   clip_reg, clip_next;
    logic                   m_valid_reg;
    logic [TERM_W-1:0]      m_term_reg;
    logic                   m_test_reg;
    logic                   m_done_reg;

    // The whole back part moves when the output register is free or taken.
    assign adv   = !m_valid_reg || m_tready;
    assign q_pop = adv && !q_empty;

    assign q_dist  = q_rdata[FLAGS_W +: INDEX_WIDTH];
    assign q_flags = item_flags_t'(q_rdata[FLAGS_W-1:0]);

    // Integer part of log2: position of the leading one.
    always_comb begin
        e_new = '0;
        for (int j = 0; j < INDEX_WIDTH; j++) begin
            if (q_dist[j]) begin
                e_new = E_W'(j);
            end
        end
    end

    // Bring the leading one to bit NORM_W-1, truncating for the widest values.
    assign wide_dist  = {a_dist_reg, {NORM_W{1'b0}}};
    assign wide_shift = wide_dist >> ((E_W + 1)'(a_e_reg) + 1'b1);

    // One squaring per fraction bit; a square of two or more gives a one.
    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_square
        logic [2*NORM_W-1:0] sq;
        assign sq         = x_reg[k] * x_reg[k];
        assign y_stage[k] = sq[2*NORM_W-1:NORM_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            v_reg       <= '0;
        end else if (adv) begin
            a_valid_reg <= !q_empty;
            v_reg       <= {v_reg[FRAC_BITS-1:0], a_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_dist_reg  <= q_dist;
            a_e_reg     <= e_new;
            a_flags_reg <= q_flags;
            x_reg[0]    <= wide_shift[NORM_W-1:0];
            bits_reg[0] <= '0;
            e_reg[0]    <= a_e_reg;
            fl_reg[0]   <= a_flags_reg;
            for (int k = 0; k < FRAC_BITS; k++) begin
                x_reg[k+1]    <= y_stage[k][NORM_W] ? y_stage[k][NORM_W:1]
                                                    : y_stage[k][NORM_W-1:0];
                bits_reg[k+1] <= {bits_reg[k][FRAC_BITS-2:0], y_stage[k][NORM_W]};
                e_reg[k+1]    <= e_reg[k];
                fl_reg[k+1]   <= fl_reg[k];
            end
        end
    end

    // Term assembly and the saturating sum.
    assign term_ext = EXT_W'({e_reg[FRAC_BITS], bits_reg[FRAC_BITS]});
    assign term_fin = fl_reg[FRAC_BITS].test ? term_ext[TERM_W-1:0] : '0;
    assign sum_add  = {1'b0, sum_reg} + (SUM_W + 1)'(term_fin);
    assign load     = adv && v_reg[FRAC_BITS];

    always_comb begin
        sum_next  = sum_reg;
        clip_next = clip_reg;
        if (load && fl_reg[FRAC_BITS].test) begin
            if (sum_add[SUM_W]) begin
                sum_next  = '1;
                clip_next = 1'b1;
            end else begin
                sum_next = sum_add[SUM_W-1:0];
            end
        end
    end

    // The sum changes only when a new result is loaded, so the output
    // shows it directly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            clip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            clip_reg <= clip_next;
            if (adv) begin
                m_valid_reg <= v_reg[FRAC_BITS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_term_reg <= term_fin;
            m_test_reg <= fl_reg[FRAC_BITS].test;
            m_done_reg <= fl_reg[FRAC_BITS].done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, clip_reg, sum_reg, m_term_reg};
    assign m_tuser  = m_test_reg;
    assign m_tlast  = m_done_reg;

endmodule

// ===== hdl/universal_test_log_distance_sum_core.sv =====
// Channel   Direction  Ports                        Contents
// ------    ---------  ---------------------------  -----------------------------------
// s_        in         s_tvalid s_tready s_tdata    block_value
// m_        out        m_tvalid m_tready m_tdata    term_log2, running_sum, saturated
//                      m_tuser m_tlast              in_test_phase, done_res
// config    in         psel penable pwrite paddr    block_len @0x0, init_blocks @0x4,
//                      pwdata prdata pready         test_blocks @0x8
//
// One item per clock is sustained while m_tready stays high; the result path runs through
// the chain of one squaring stage per fraction bit of the log2 unit.
// After reset the block clears all 2^MAX_BLOCK_LEN table entries (65536 by default)
// with s_tready low; register writes are taken during that pass.
// With a result waiting and m_tready low the back part holds; a four-entry queue lets
// the front keep taking items until it fills.
module universal_test_log_distance_sum_core #(
    parameter int MAX_BLOCK_LEN = utld_pkg::MAX_BLOCK_LEN_DEF,
    parameter int INDEX_WIDTH   = utld_pkg::INDEX_WIDTH_DEF,
    parameter int FRAC_BITS     = utld_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input transfer
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] block_value
    input  logic [utld_pkg::BLOCK_VALUE_W-1:0] s_tdata,
    // Result transfer
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [20:0] term_log2, [68:21] running_sum, [69] saturated, [71:70] zero
    output logic [utld_pkg::TDATA_OUT_W-1:0]   m_tdata,
    // [0] in_test_phase
    output logic                               m_tuser,
    output logic                               m_tlast,
    // Configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [utld_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [utld_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [utld_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    import utld_pkg::*;

    localparam int QW = INDEX_WIDTH + FLAGS_W;

    cfg_t                   cfg_reg, cfg_next;
    logic                   cfg_wr;

    logic                   q_push;
    logic [INDEX_WIDTH-1:0] q_dist;
    item_flags_t            q_flags;
    logic [QW-1:0]          q_rdata;
    logic                   q_pop;
    logic                   q_empty;
    logic [QUEUE_LVL_W-1:0] q_level;

    // Register writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_BLOCK_LEN:   cfg_next.block_len   = pwdata[BLOCK_LEN_W-1:0];
                REG_INIT_BLOCKS: cfg_next.init_blocks = pwdata[INIT_BLOCKS_W-1:0];
                REG_TEST_BLOCKS: cfg_next.test_blocks = pwdata[TEST_BLOCKS_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_len   <= BLOCK_LEN_RST;
            cfg_reg.init_blocks <= INIT_BLOCKS_RST;
            cfg_reg.test_blocks <= TEST_BLOCKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_BLOCK_LEN:   prdata = APB_DATA_W'(cfg_reg.block_len);
            REG_INIT_BLOCKS: prdata = APB_DATA_W'(cfg_reg.init_blocks);
            REG_TEST_BLOCKS: prdata = APB_DATA_W'(cfg_reg.test_blocks);
            default:         prdata = '0;
        endcase
    end

    utld_front #(
        .MAX_BLOCK_LEN (MAX_BLOCK_LEN),
        .INDEX_WIDTH   (INDEX_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_level  (q_level),
        .q_push   (q_push),
        .q_dist   (q_dist),
        .q_flags  (q_flags)
    );

    utld_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   ({q_dist, q_flags}),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty),
        .level   (q_level)
    );

    utld_back #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/utld_checker.sv =====
module utld_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [utld_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic                             m_tuser,
    input logic                             m_tlast
);

    import utld_pkg::*;

    logic                 seen_reg;
    logic                 sat_seen_reg;
    logic [SUM_W-1:0]     last_sum_reg;
    logic [SUM_W-1:0]     cur_sum;
    logic                 delivered;

    assign cur_sum   = m_tdata[SUM_LSB +: SUM_W];
    assign delivered = m_tvalid && m_tready;

    // History of delivered results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= 1'b0;
            sat_seen_reg <= 1'b0;
            last_sum_reg <= '0;
        end else if (delivered) begin
            seen_reg     <= 1'b1;
            sat_seen_reg <= sat_seen_reg || m_tdata[SAT_BIT];
            last_sum_reg <= cur_sum;
        end
    end

    // The table is being cleared right after reset, so no input is taken.
    a_busy_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // Initialization and ignored items carry no log2 term.
    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[TERM_LSB +: TERM_W] == '0)
        else $error("nonzero term outside the test phase");

    // The running sum never goes down.
    a_sum_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_reg |-> cur_sum >= last_sum_reg)
        else $error("running sum decreased");

    // Saturation is sticky and pins the sum at its maximum.
    a_sat_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && sat_seen_reg |-> m_tdata[SAT_BIT] && (cur_sum == '1))
        else $error("saturation flag or clipped sum lost");

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind universal_test_log_distance_sum_core utld_checker u_utld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_universal_test_log_distance_sum_core.sv =====
`timescale 1ns / 1ps

module tb_universal_test_log_distance_sum_core;
    import utld_pkg::*;

    localparam longint unsigned INDEX_MAX = (64'd1 << INDEX_WIDTH_DEF) - 1;
    localparam longint unsigned SUM_MAX   = (64'd1 << SUM_W) - 1;

    // One result transfer, split into its fields.
    typedef struct {
        logic [TERM_W-1:0] term;
        logic [SUM_W-1:0]  sum;
        logic              test;
        logic              done;
        logic              sat;
    } dist_result_t;

    logic                     aclk;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [BLOCK_VALUE_W-1:0] s_tdata  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]   m_tdata;
    logic                     m_tuser;
    logic                     m_tlast;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr    = '0;
    logic [APB_DATA_W-1:0]    pwdata   = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    universal_test_log_distance_sum_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Blocks waiting to be sent and results waiting to be seen.
    logic [BLOCK_VALUE_W-1:0] block_stream [$];
    dist_result_t             expected_results [$];

    // Shadow of the configuration and of the test state.
    logic [BLOCK_LEN_W-1:0]   cfg_block_len   = BLOCK_LEN_RST;
    logic [INIT_BLOCKS_W-1:0] cfg_init_blocks = INIT_BLOCKS_RST;
    logic [TEST_BLOCKS_W-1:0] cfg_test_blocks = TEST_BLOCKS_RST;
    int unsigned              last_seen [1 << MAX_BLOCK_LEN_DEF];
    longint unsigned          block_count = 0;
    longint unsigned          distance_sum = 0;
    logic                     sum_clipped = 1'b0;

    int                       errors = 0;
    int                       result_count = 0;
    logic                     no_gaps = 1'b0;
    logic                     hold_send = 1'b0;
    logic [BLOCK_VALUE_W-1:0] last_block = '0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // Fixed-point log2 by repeated squaring of the normalized mantissa.
    function automatic logic [TERM_W-1:0] log2_fixed(input longint unsigned d);
        int unsigned     e;
        longint unsigned x;
        longint unsigned bits;
        e = 0;
        bits = 0;
        while (e < 63 && (d >> (e + 1)) != 0) begin
            e++;
        end
        if (e <= 30) begin
            x = d << (30 - e);
        end else begin
            x = d >> (e - 30);
        end
        for (int k = 0; k < FRAC_BITS_DEF; k++) begin
            x = (x * x) >> 30;
            bits = bits << 1;
            if (x >= (64'd1 << 31)) begin
                bits = bits | 1;
                x = x >> 1;
            end
        end
        return TERM_W'((longint'(e) << FRAC_BITS_DEF) | bits);
    endfunction

    // Advance the test state by one block and return the result it causes.
    function automatic dist_result_t distance_step(input logic [BLOCK_VALUE_W-1:0] value);
        dist_result_t      r;
        int unsigned       len;
        int unsigned       v;
        longint unsigned   end_idx;
        longint unsigned   i;
        logic [TERM_W-1:0] term;
        r.term = '0;
        r.test = 1'b0;
        r.done = 1'b0;
        len = cfg_block_len;
        if (len < MIN_BLOCK_LEN) begin
            len = MIN_BLOCK_LEN;
        end
        if (len > MAX_BLOCK_LEN_DEF) begin
            len = MAX_BLOCK_LEN_DEF;
        end
        end_idx = longint'(cfg_init_blocks) + longint'(cfg_test_blocks);
        if (end_idx > INDEX_MAX) begin
            end_idx = INDEX_MAX;
        end
        if (block_count >= end_idx) begin
            // Past the end: state holds, only the done flag is raised.
            r.done = 1'b1;
        end else begin
            i = block_count + 1;
            block_count = i;
            v = 32'(value) & ((32'd1 << len) - 1);
            if (i > cfg_init_blocks) begin
                term = log2_fixed(i - last_seen[v]);
                if (distance_sum > SUM_MAX - term) begin
                    distance_sum = SUM_MAX;
                    sum_clipped = 1'b1;
                end else begin
                    distance_sum = distance_sum + term;
                end
                r.term = term;
                r.test = 1'b1;
                r.done = (i == end_idx);
            end
            last_seen[v] = int'(i);
        end
        r.sum = distance_sum[SUM_W-1:0];
        r.sat = sum_clipped;
        return r;
    endfunction

    // Block sender: a new transfer is offered once the previous one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (block_stream.size() != 0 && !hold_send
                && (no_gaps || $urandom_range(0, 99) >= 34)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= block_stream.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver stalls at random unless no_gaps is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_gaps || ($urandom_range(0, 99) >= 34);
        end
    end

    // Predict on every accepted block, check every accepted result.
    always @(posedge aclk) begin : monitor
        dist_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(distance_step(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              result_count));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[TERM_LSB +: TERM_W] !== want.term)
                        report_mismatch($sformatf("result %0d term_log2 %h, expected %h",
                            result_count, m_tdata[TERM_LSB +: TERM_W], want.term));
                    if (m_tdata[SUM_LSB +: SUM_W] !== want.sum)
                        report_mismatch($sformatf("result %0d running_sum %h, expected %h",
                            result_count, m_tdata[SUM_LSB +: SUM_W], want.sum));
                    if (m_tdata[SAT_BIT] !== want.sat)
                        report_mismatch($sformatf("result %0d saturated %b, expected %b",
                            result_count, m_tdata[SAT_BIT], want.sat));
                    if (m_tuser !== want.test)
                        report_mismatch($sformatf("result %0d in_test_phase %b, expected %b",
                            result_count, m_tuser, want.test));
                    if (m_tlast !== want.done)
                        report_mismatch($sformatf("result %0d done_res %b, expected %b",
                            result_count, m_tlast, want.done));
                end
                result_count++;
            end
        end
    end

    // Register write followed by a read back of the stored value.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] stored;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_BLOCK_LEN: begin
                cfg_block_len = value[BLOCK_LEN_W-1:0];
                stored = 32'(cfg_block_len);
            end
            REG_INIT_BLOCKS: begin
                cfg_init_blocks = value[INIT_BLOCKS_W-1:0];
                stored = 32'(cfg_init_blocks);
            end
            default: begin
                cfg_test_blocks = value[TEST_BLOCKS_W-1:0];
                stored = 32'(cfg_test_blocks);
            end
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== stored)
            report_mismatch($sformatf("register %s read %h, expected %h",
                                      idx.name(), prdata, stored));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every block has been sent and every result checked.
    task automatic wait_drained();
        do @(negedge aclk);
        while (block_stream.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    // Random blocks: in part a small alphabet so values recur at short distances,
    // with garbage above the block length, plus repeats and full-width values.
    task automatic queue_random_blocks(input int count);
        int unsigned len;
        int unsigned mask;
        int unsigned pick;
        len = cfg_block_len;
        if (len < MIN_BLOCK_LEN) len = MIN_BLOCK_LEN;
        if (len > MAX_BLOCK_LEN_DEF) len = MAX_BLOCK_LEN_DEF;
        mask = (32'd1 << len) - 1;
        @(negedge aclk);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                block_stream.push_back(last_block);
            end else if (pick < 55) begin
                last_block = BLOCK_VALUE_W'(($urandom & ~mask) | $urandom_range(0, 15));
                block_stream.push_back(last_block);
            end else begin
                last_block = BLOCK_VALUE_W'($urandom);
                block_stream.push_back(last_block);
            end
        end
    endtask

    // Hold the sender partway through a batch until the block has drained.
    task automatic pause_sender_midway(input int left);
        do @(negedge aclk); while (block_stream.size() > left);
        hold_send = 1'b1;
        do @(negedge aclk); while (s_tvalid || expected_results.size() != 0);
        hold_send = 1'b0;
    endtask

    initial begin
        wait (aresetn);

        // Short block length below range, four init blocks, sixteen test blocks.
        write_reg(REG_BLOCK_LEN, 32'd0);
        write_reg(REG_INIT_BLOCKS, 32'd4);
        write_reg(REG_TEST_BLOCKS, 32'd16);
        @(negedge aclk);
        block_stream = '{16'h0000, 16'hFFFF, 16'h0040, 16'h003F,
                         16'h0000, 16'h0000, 16'h1234, 16'hAAAA, 16'h5555, 16'hFFFF,
                         16'h8000, 16'h7FFF, 16'h0001, 16'h0002, 16'h0004, 16'h0008,
                         16'h0010, 16'h0020, 16'h0003, 16'h0005,
                         16'hFFFF, 16'h0000, 16'h1111};
        wait_drained();

        // No initialization and no test blocks: everything is ignored.
        write_reg(REG_INIT_BLOCKS, 32'd0);
        write_reg(REG_TEST_BLOCKS, 32'd0);
        queue_random_blocks(4);
        wait_drained();

        // Block length above range, largest test count, no idling on either side.
        write_reg(REG_BLOCK_LEN, 32'd31);
        write_reg(REG_TEST_BLOCKS, 32'h7FF_FFFF);
        no_gaps = 1'b1;
        queue_random_blocks(350);
        wait_drained();
        no_gaps = 1'b0;

        // Largest init count with the end point clamped: only initialization blocks.
        write_reg(REG_BLOCK_LEN, 32'd16);
        write_reg(REG_INIT_BLOCKS, 32'hF_FFFF);
        queue_random_blocks(150);
        pause_sender_midway(75);
        wait_drained();

        // One init block, test run ending three hundred blocks past the current count.
        write_reg(REG_BLOCK_LEN, 32'd5);
        write_reg(REG_INIT_BLOCKS, 32'd1);
        write_reg(REG_TEST_BLOCKS, 32'(block_count + 299));
        queue_random_blocks(320);
        wait_drained();

        write_reg(REG_BLOCK_LEN, 32'd8);
        write_reg(REG_TEST_BLOCKS, 32'(block_count + 400));
        queue_random_blocks(400);
        pause_sender_midway(180);
        wait_drained();

        // Initialization resumes for a hundred blocks, then two hundred test blocks.
        write_reg(REG_BLOCK_LEN, 32'd12);
        write_reg(REG_INIT_BLOCKS, 32'(block_count + 100));
        write_reg(REG_TEST_BLOCKS, 32'd200);
        queue_random_blocks(310);
        wait_drained();

        // A single test block.
        write_reg(REG_BLOCK_LEN, 32'd17);
        write_reg(REG_INIT_BLOCKS, 32'(block_count));
        write_reg(REG_TEST_BLOCKS, 32'd1);
        queue_random_blocks(3);
        wait_drained();

        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("[universal_test_log_distance_sum_core] OK");
        end else begin
            $display("[universal_test_log_distance_sum_core] ERROR");
        end
        $finish;
    end

    // Run limit, well beyond the clearing pass plus the slowest stimulus.
    initial begin
        #5ms;
        $display("[universal_test_log_distance_sum_core] ERROR");
        $finish;
    end

endmodule

// ===== universal_test_log_distance_sum_core.f =====
hdl/utld_pkg.sv
hdl/utld_ram.sv
hdl/utld_fifo.sv
hdl/utld_front.sv
hdl/utld_back.sv
hdl/universal_test_log_distance_sum_core.sv
hdl/utld_checker.sv
tb/tb_universal_test_log_distance_sum_core.sv
